[rtl/fee_pkg.sv]
package fee_pkg;

   localparam int SHADOW_BYTES_DEF = 255;
   localparam int PAGE_WORDS_DEF   = 512;

   localparam logic [15:0] VALID_MARK  = 16'h4F4B;
   localparam logic [15:0] ERASED_WORD = 16'hFFFF;
   localparam logic [7:0]  ERASED_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      OP_READ    = 2'd0,
      OP_WRITE   = 2'd1,
      OP_REBUILD = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [14:0] {
      ST_CLR    = 15'h0001,
      ST_IDLE   = 15'h0002,
      ST_MA0    = 15'h0004,
      ST_MA1    = 15'h0008,
      ST_MB1    = 15'h0010,
      ST_IERASE = 15'h0020,
      ST_SCLR   = 15'h0040,
      ST_RPRD   = 15'h0080,
      ST_RPCK   = 15'h0100,
      ST_SRD    = 15'h0200,
      ST_SCK    = 15'h0400,
      ST_CERASE = 15'h0800,
      ST_CSRD   = 15'h1000,
      ST_CSCK   = 15'h2000,
      ST_OERASE = 15'h4000
   } state_type;

endpackage

[rtl/flash_eeprom_emulation_unit.sv]
// channel  ports        tdata (low bit up)                          tuser
// request  req_t*       address[7:0], data[15:8]                    op[1:0]
// response rsp_t*       read_data[7:0], record_written[8],          -
//                       compacted[9], zero fill[15:10]
//
// After reset the flash array is swept to all ones; no requests are taken meanwhile.
// Read or logged write: shadow RAM read, compare, and a flash program for a write that changes the byte.
// First use or rebuild: page marks read, shadow RAM cleared, each logged record replayed;
// page A is erased and marked first when it has to be.
// Compaction: erase and mark the other page, copy the live shadow bytes into it, erase the old page.
// One request at a time; a finished response waits in the output register
// while the next request is accepted.
module flash_eeprom_emulation_unit
   import fee_pkg::*;
#(
   parameter int SHADOW_BYTES = SHADOW_BYTES_DEF,
   parameter int PAGE_WORDS   = PAGE_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // address[7:0], data[15:8]
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // read_data[7:0], record_written, compacted, zeros
);

   localparam int SH_W   = (SHADOW_BYTES > 1) ? $clog2(SHADOW_BYTES) : 1;
   localparam int FA_W   = $clog2(2 * PAGE_WORDS);
   localparam int CNT_W  = FA_W + 1;
   localparam int SLOT_W = $clog2(PAGE_WORDS + 1);

   logic [15:0] flash_mem [2*PAGE_WORDS];
   logic [7:0]  shadow_mem [SHADOW_BYTES];

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic             page_ff, page_in;
   logic             ready_ff, ready_in;
   op_type           op_ff, op_in;
   logic [7:0]       addr_ff, addr_in;
   logic [7:0]       data_ff, data_in;
   logic [7:0]       res_rd_ff, res_rd_in;
   logic             res_rec_ff, res_rec_in;
   logic             res_comp_ff, res_comp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [9:0]       rsp_data_ff, rsp_data_in;
   logic             pend_ff, pend_in;

   logic [FA_W-1:0]  fr_addr, fw_addr;
   logic [15:0]      fw_data, fr_q_ff;
   logic             fw_en;
   logic [SH_W-1:0]  sr_addr, sw_addr;
   logic [7:0]       sw_data, sr_q_ff;
   logic             sw_en;

   logic             in_range;
   logic             accept;
   logic             rsp_free;

   assign in_range   = (addr_ff < 8'(SHADOW_BYTES));
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !pend_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   function automatic logic [FA_W-1:0] fa(input logic page, input logic [CNT_W-1:0] off);
      fa = (page ? FA_W'(PAGE_WORDS) : FA_W'(0)) + FA_W'(off);
   endfunction

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      slot_in     = slot_ff;
      page_in     = page_ff;
      ready_in    = ready_ff;
      op_in       = op_ff;
      addr_in     = addr_ff;
      data_in     = data_ff;
      res_rd_in   = res_rd_ff;
      res_rec_in  = res_rec_ff;
      res_comp_in = res_comp_ff;
      pend_in     = pend_ff;
      fr_addr     = '0;
      fw_en       = 1'b0;
      fw_addr     = '0;
      fw_data     = ERASED_WORD;
      sr_addr     = '0;
      sw_en       = 1'b0;
      sw_addr     = '0;
      sw_data     = ERASED_BYTE;

      // a finished response moves to the output register when it is free
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (pend_ff && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res_comp_ff, res_rec_ff, res_rd_ff};
         pend_in      = 1'b0;
      end

      case (state_ff)
         ST_CLR: begin
            fw_en   = 1'b1;
            fw_addr = FA_W'(cnt_ff);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(2 * PAGE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in       = op_type'(req_tuser);
               addr_in     = req_tdata[7:0];
               data_in     = req_tdata[15:8];
               res_rd_in   = '0;
               res_rec_in  = 1'b0;
               res_comp_in = 1'b0;
               case (op_type'(req_tuser))
                  OP_NONE: begin
                     pend_in = 1'b1;
                  end
                  OP_REBUILD: begin
                     state_in = ST_MA0;
                  end
                  default: begin
                     state_in = ready_ff ? ST_SRD : ST_MA0;
                  end
               endcase
            end
         end
         ST_MA0: begin
            fr_addr  = '0;
            state_in = ST_MA1;
         end
         ST_MA1: begin
            cnt_in = '0;
            if (fr_q_ff == VALID_MARK) begin
               page_in  = 1'b0;
               state_in = ST_SCLR;
            end else begin
               fr_addr  = FA_W'(PAGE_WORDS);
               state_in = ST_MB1;
            end
         end
         ST_MB1: begin
            cnt_in = '0;
            if (fr_q_ff == VALID_MARK) begin
               page_in  = 1'b1;
               state_in = ST_SCLR;
            end else begin
               page_in  = 1'b0;
               state_in = ST_IERASE;
            end
         end
         ST_IERASE: begin
            fw_en   = 1'b1;
            fw_addr = fa(1'b0, cnt_ff);
            fw_data = (cnt_ff == '0) ? VALID_MARK : ERASED_WORD;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PAGE_WORDS - 1)) begin
               cnt_in   = '0;
               state_in = ST_SCLR;
            end
         end
         ST_SCLR: begin
            sw_en   = 1'b1;
            sw_addr = SH_W'(cnt_ff);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SHADOW_BYTES - 1)) begin
               slot_in  = SLOT_W'(1);
               state_in = ST_RPRD;
            end
         end
         ST_RPRD: begin
            if (slot_ff < SLOT_W'(PAGE_WORDS)) begin
               fr_addr  = fa(page_ff, CNT_W'(slot_ff));
               state_in = ST_RPCK;
            end else begin
               ready_in = 1'b1;
               if (op_ff == OP_REBUILD) begin
                  pend_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SRD;
               end
            end
         end
         ST_RPCK: begin
            if (fr_q_ff[7:0] >= 8'(SHADOW_BYTES)) begin
               ready_in = 1'b1;
               if (op_ff == OP_REBUILD) begin
                  pend_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SRD;
               end
            end else begin
               sw_en    = 1'b1;
               sw_addr  = SH_W'(fr_q_ff[7:0]);
               sw_data  = fr_q_ff[15:8];
               slot_in  = slot_ff + 1'b1;
               state_in = ST_RPRD;
            end
         end
         ST_SRD: begin
            sr_addr  = SH_W'(addr_ff);
            state_in = ST_SCK;
         end
         ST_SCK: begin
            state_in = ST_IDLE;
            pend_in  = 1'b1;
            if (op_ff == OP_READ) begin
               res_rd_in = in_range ? sr_q_ff : ERASED_BYTE;
            end else if (in_range && sr_q_ff != data_ff) begin
               sw_en      = 1'b1;
               sw_addr    = SH_W'(addr_ff);
               sw_data    = data_ff;
               res_rec_in = 1'b1;
               if (slot_ff >= SLOT_W'(PAGE_WORDS)) begin
                  // page full: compact into the other page
                  pend_in  = 1'b0;
                  cnt_in   = '0;
                  state_in = ST_CERASE;
               end else begin
                  fw_en   = 1'b1;
                  fw_addr = fa(page_ff, CNT_W'(slot_ff));
                  fw_data = {data_ff, addr_ff};
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         ST_CERASE: begin
            fw_en   = 1'b1;
            fw_addr = fa(!page_ff, cnt_ff);
            fw_data = (cnt_ff == '0) ? VALID_MARK : ERASED_WORD;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PAGE_WORDS - 1)) begin
               cnt_in   = '0;
               slot_in  = SLOT_W'(1);
               state_in = ST_CSRD;
            end
         end
         ST_CSRD: begin
            sr_addr  = SH_W'(cnt_ff);
            state_in = ST_CSCK;
         end
         ST_CSCK: begin
            if (sr_q_ff != ERASED_BYTE) begin
               fw_en   = 1'b1;
               fw_addr = fa(!page_ff, CNT_W'(slot_ff));
               fw_data = {sr_q_ff, cnt_ff[7:0]};
               slot_in = slot_ff + 1'b1;
            end
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_CSRD;
            if (cnt_ff == CNT_W'(SHADOW_BYTES - 1)) begin
               cnt_in   = '0;
               state_in = ST_OERASE;
            end
         end
         ST_OERASE: begin
            fw_en   = 1'b1;
            fw_addr = fa(page_ff, cnt_ff);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PAGE_WORDS - 1)) begin
               page_in     = !page_ff;
               res_comp_in = 1'b1;
               pend_in     = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         cnt_ff       <= '0;
         slot_ff      <= SLOT_W'(1);
         page_ff      <= 1'b0;
         ready_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         slot_ff      <= slot_in;
         page_ff      <= page_in;
         ready_ff     <= ready_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      data_ff     <= data_in;
      res_rd_ff   <= res_rd_in;
      res_rec_ff  <= res_rec_in;
      res_comp_ff <= res_comp_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (fw_en) begin
         flash_mem[fw_addr] <= fw_data;
      end
      fr_q_ff <= flash_mem[fr_addr];
   end

   always_ff @(posedge clock) begin
      if (sw_en) begin
         shadow_mem[sw_addr] <= sw_data;
      end
      sr_q_ff <= shadow_mem[sr_addr];
   end

endmodule
